### rtl/scpf_pkg.sv
// Package for the sensor command packet framer.
// Holds the command record passed from front to back and the serializer step codes.
// No dependencies.
package scpf_pkg;

	localparam logic [7:0] SYNC_HI   = 8'hEF;
	localparam logic [7:0] SYNC_LO   = 8'h01;
	localparam logic [7:0] PACKET_ID = 8'h01;

	typedef struct packed {
		logic        is_start;
		logic        has_param;
		logic        do_cksum;
		logic [31:0] addr;
		logic [15:0] len;
		logic [7:0]  instr;
		logic [7:0]  pbyte;
		logic [15:0] cksum;
	} cmd_t;

	typedef enum logic [12:0] {
		ST_SYNC0 = 13'b0000000000001,
		ST_SYNC1 = 13'b0000000000010,
		ST_ADDR3 = 13'b0000000000100,
		ST_ADDR2 = 13'b0000000001000,
		ST_ADDR1 = 13'b0000000010000,
		ST_ADDR0 = 13'b0000000100000,
		ST_PID   = 13'b0000001000000,
		ST_LENH  = 13'b0000010000000,
		ST_LENL  = 13'b0000100000000,
		ST_INSTR = 13'b0001000000000,
		ST_PARAM = 13'b0010000000000,
		ST_CKHI  = 13'b0100000000000,
		ST_CKLO  = 13'b1000000000000
	} step_t;

endpackage

### rtl/scpf_front.sv
// Front end: takes input transfers, tracks packet position and checksum,
// and builds one command per item. Holds the module address register. Uses scpf_pkg.
module scpf_front import scpf_pkg::*; #(
	parameter int MAX_PARAMS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	localparam int SAT = (MAX_PARAMS < 255) ? MAX_PARAMS : 255;
	localparam logic [7:0] SAT_CNT = SAT[7:0];

	logic [31:0] addr_q;
	logic [7:0]  rem_q;
	logic [15:0] sum_q;

	logic [7:0]  instr, count_in, pbyte, cnt;
	logic        start;
	logic [15:0] len, base_sum, new_sum;
	logic [7:0]  rem_nxt;

	assign instr    = s_tdata[7:0];
	assign count_in = s_tdata[15:8];
	assign pbyte    = s_tdata[23:16];

	assign s_tready  = !q_full;
	assign cfg_ready = 1'b1;
	assign q_push    = s_tvalid && s_tready;

	assign start = (rem_q == 8'd0);
	assign cnt   = (count_in > SAT_CNT) ? SAT_CNT : count_in;
	assign len   = {8'd0, cnt} + 16'd3;

	assign base_sum = {8'd0, PACKET_ID} + {8'd0, len[15:8]} + {8'd0, len[7:0]}
		+ {8'd0, instr} + ((cnt != 8'd0) ? {8'd0, pbyte} : 16'd0);
	assign new_sum  = start ? base_sum : (sum_q + {8'd0, pbyte});
	assign rem_nxt  = start ? ((cnt == 8'd0) ? 8'd0 : (cnt - 8'd1)) : (rem_q - 8'd1);

	always_comb begin
		q_cmd.is_start  = start;
		q_cmd.has_param = !start || (cnt != 8'd0);
		q_cmd.do_cksum  = (rem_nxt == 8'd0);
		q_cmd.addr      = addr_q;
		q_cmd.len       = len;
		q_cmd.instr     = instr;
		q_cmd.pbyte     = pbyte;
		q_cmd.cksum     = new_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= 32'hFFFF_FFFF;
			rem_q  <= 8'd0;
			sum_q  <= 16'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				addr_q <= cfg_data;
			end
			if (q_push) begin
				rem_q <= rem_nxt;
				sum_q <= (rem_nxt == 8'd0) ? 16'd0 : new_sum;
			end
		end
	end

endmodule

### rtl/scpf_cmd_fifo.sv
// Two-entry command queue between front and back.
// Uses scpf_pkg for the command record.
module scpf_cmd_fifo import scpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/scpf_back.sv
// Back end: serializes one command into packet bytes, one per cycle unless the
// output is stalled by m_tready, through a registered output stage. Uses scpf_pkg.
module scpf_back import scpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       q_head,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic       m_tuser
);

	cmd_t       cur_q;
	step_t      step_q, step_nxt;
	logic       active_q;
	logic       m_tvalid_q, m_tlast_q, m_tuser_q;
	logic [7:0] m_tdata_q;
	logic       emit, last, load;
	logic [7:0] byte_val;

	assign emit  = active_q && (!m_tvalid_q || m_tready);
	assign load  = !q_empty && (!active_q || (emit && last));
	assign q_pop = load;

	always_comb begin
		byte_val = 8'd0;
		step_nxt = step_q;
		last     = 1'b0;
		case (step_q)
			ST_SYNC0: begin byte_val = SYNC_HI;            step_nxt = ST_SYNC1; end
			ST_SYNC1: begin byte_val = SYNC_LO;            step_nxt = ST_ADDR3; end
			ST_ADDR3: begin byte_val = cur_q.addr[31:24];  step_nxt = ST_ADDR2; end
			ST_ADDR2: begin byte_val = cur_q.addr[23:16];  step_nxt = ST_ADDR1; end
			ST_ADDR1: begin byte_val = cur_q.addr[15:8];   step_nxt = ST_ADDR0; end
			ST_ADDR0: begin byte_val = cur_q.addr[7:0];    step_nxt = ST_PID;   end
			ST_PID:   begin byte_val = PACKET_ID;          step_nxt = ST_LENH;  end
			ST_LENH:  begin byte_val = cur_q.len[15:8];    step_nxt = ST_LENL;  end
			ST_LENL:  begin byte_val = cur_q.len[7:0];     step_nxt = ST_INSTR; end
			ST_INSTR: begin
				byte_val = cur_q.instr;
				if (cur_q.has_param) step_nxt = ST_PARAM;
				else if (cur_q.do_cksum) step_nxt = ST_CKHI;
				else last = 1'b1;
			end
			ST_PARAM: begin
				byte_val = cur_q.pbyte;
				if (cur_q.do_cksum) step_nxt = ST_CKHI;
				else last = 1'b1;
			end
			ST_CKHI:  begin byte_val = cur_q.cksum[15:8];  step_nxt = ST_CKLO;  end
			ST_CKLO:  begin byte_val = cur_q.cksum[7:0];   last = 1'b1;         end
			default:  begin byte_val = 8'd0;               last = 1'b1;         end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_head;
		end
		if (emit) begin
			m_tdata_q <= byte_val;
			m_tlast_q <= last;
			m_tuser_q <= (step_q == ST_CKLO);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			step_q     <= ST_SYNC0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (load) begin
				active_q <= 1'b1;
				step_q   <= q_head.is_start ? ST_SYNC0 : ST_PARAM;
			end else if (emit) begin
				if (last) active_q <= 1'b0;
				else step_q <= step_nxt;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("packet end without tlast");

	a_step_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> $onehot(step_q))
		else $error("serializer step not one-hot");

	a_cklo_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit && (step_q == ST_CKLO) |=> m_tvalid && m_tuser && m_tlast)
		else $error("low checksum byte not marked as packet end");

	a_no_pop_mid_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!active_q || last))
		else $error("command taken while previous one unfinished");

endmodule

### rtl/sensor_command_packet_framer.sv
// Top level of the sensor command packet framer: front, command queue, back.
// Depends on scpf_pkg, scpf_front, scpf_cmd_fifo, scpf_back.
//
// Each input transfer is one item of a command packet. The first item of a packet emits
// the header EF 01, the four module address bytes (cfg_data, big-endian, reset FFFFFFFF),
// packet id 01, the length (count + 3, count saturated to MAX_PARAMS), the instruction
// and the first parameter byte if any; each later item emits one parameter byte. The item
// that completes the packet also emits the two checksum bytes (16-bit sum from packet id
// on). A packet's first item thus makes 11 to 13 output bytes, a later item 1 or 3; the
// back-end serializer moves one byte per cycle while m_tready does not stall it, and when
// idle it first loads a command from the queue. The front accepts one item per cycle while its
// two-entry command queue has room. m_tlast marks the last byte of each item, m_tuser the
// low checksum byte that ends a packet.
module sensor_command_packet_framer import scpf_pkg::*; #(
	parameter int MAX_PARAMS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] instruction, [15:8] param_count, [23:16] param_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	output logic        m_tuser,   // [0] packet_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	cmd_t push_cmd, head;
	logic push, full, pop, empty;

	scpf_front #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.q_full   (full),
		.q_push   (push),
		.q_cmd    (push_cmd)
	);

	scpf_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	scpf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (empty),
		.q_head  (head),
		.q_pop   (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule
